// ===== design/jrm_pkg.sv =====
// Package with shared constants, codes and control types of the journal replay map.
package jrm_pkg;

	// Table geometry.
	localparam int MAP_ENTRIES = 64;
	localparam int IDX_W       = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
	localparam int CNT_W       = 7;
	localparam int ENTRY_W     = 128;

	// Event operation codes.
	typedef enum logic [1:0] {
		OP_TAG    = 2'd0,
		OP_COMMIT = 2'd1,
		OP_REVOKE = 2'd2,
		OP_FINISH = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_COMMIT   = 3'd3,
		ST_REVOKE   = 3'd4,
		ST_REPLAY   = 3'd5,
		ST_NONE     = 3'd6
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic rd;
		logic inc;
		logic tag_hit;
		logic rev_mark;
		logic fin_keep;
		logic done;
	} jrm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		op_t  in_op;
		op_t  op;
		logic used_zero;
		logic idx_last;
		logic tag_match;
		logic rev_match;
		logic qualify;
		logic pend_v;
		logic out_free;
	} jrm_stat_t;

endpackage

// ===== design/jrm_if.sv =====
// Channel interfaces for events, results and configuration writes.
interface jrm_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [63:0] fs_block;
	logic [31:0] log_position;
	logic [31:0] sequence_req;
	modport source (output valid, operation, fs_block, log_position, sequence_req, input ready);
	modport sink (input valid, operation, fs_block, log_position, sequence_req, output ready);
endinterface

interface jrm_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] out_fs_block;
	logic [31:0] out_log_block;
	logic [31:0] entry_sequence;
	logic [31:0] last_committed;
	logic [6:0]  entry_count;
	logic        revoke_hit;
	logic        last;
	modport source (output valid, status, out_fs_block, out_log_block, entry_sequence,
		last_committed, entry_count, revoke_hit, last, input ready);
	modport sink (input valid, status, out_fs_block, out_log_block, entry_sequence,
		last_committed, entry_count, revoke_hit, last, output ready);
endinterface

interface jrm_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== design/jrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module jrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/jrm_datapath.sv =====
// Datapath of the journal replay map: table storage, scan index, marks and result register.
module jrm_datapath
	import jrm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	jrm_evt_if.sink     evt,
	jrm_res_if.source   res,
	jrm_cfg_if.sink     cfg,
	input  jrm_cmd_t    cmd,
	output jrm_stat_t   stat
);

	op_t                    op_q;
	logic [63:0]            fsb_q;
	logic [31:0]            pos_q;
	logic [31:0]            seq_q;
	logic [31:0]            log_size_q;
	logic [IDX_W-1:0]       idx_q;
	logic [CNT_W-1:0]       used_q;
	logic [31:0]            highest_q;
	logic [MAP_ENTRIES-1:0] revoked_q;
	logic                   found_q;
	logic [IDX_W-1:0]       slot_q;
	logic                   hit_q;
	logic                   pend_v_q;
	logic [63:0]            pend_fsb_q;
	logic [31:0]            pend_lb_q;
	logic [31:0]            pend_seq_q;
	logic                   out_valid_q;
	status_t                out_status_q;
	logic [63:0]            out_fsb_q;
	logic [31:0]            out_lb_q;
	logic [31:0]            out_seq_q;
	logic [31:0]            out_high_q;
	logic [CNT_W-1:0]       out_cnt_q;
	logic                   out_hit_q;
	logic                   out_last_q;

	logic                   load;
	logic [ENTRY_W-1:0]     rdata;
	logic [63:0]            r_fsb;
	logic [31:0]            r_lb;
	logic [31:0]            r_seq;
	logic [31:0]            wrapped;
	logic                   has_room;
	logic                   tag_write;
	logic [IDX_W-1:0]       waddr;
	logic [31:0]            high_next;
	logic [CNT_W-1:0]       used_next;
	logic                   out_free;
	status_t                done_status;

	assign load      = cmd.take && evt.valid;
	assign evt.ready = cmd.take;
	assign cfg.ready = 1'b1;

	assign r_fsb = rdata[127:64];
	assign r_lb  = rdata[63:32];
	assign r_seq = rdata[31:0];

	// Single conditional wrap of the log position.
	assign wrapped   = (pos_q >= log_size_q) ? (pos_q - log_size_q) : pos_q;
	assign has_room  = used_q < CNT_W'(MAP_ENTRIES);
	assign tag_write = cmd.done && (op_q == OP_TAG) && (found_q || has_room);
	assign waddr     = found_q ? slot_q : used_q[IDX_W-1:0];
	assign high_next = (seq_q > highest_q) ? seq_q : highest_q;
	assign out_free  = !out_valid_q || res.ready;

	// Table storage: block, wrapped position and sequence per entry.
	jrm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAP_ENTRIES)) u_table (
		.clk   (clk),
		.we    (tag_write),
		.waddr (waddr),
		.wdata ({fsb_q, wrapped, seq_q}),
		.re    (cmd.rd),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// Entry count and result status after the finishing step of the current transaction.
	always_comb begin
		used_next   = used_q;
		done_status = ST_COMMIT;
		case (op_q)
			OP_TAG: begin
				if (found_q) begin
					done_status = ST_UPDATED;
				end else if (has_room) begin
					done_status = ST_INSERTED;
					used_next   = used_q + CNT_W'(1);
				end else begin
					done_status = ST_DROPPED;
				end
			end
			OP_COMMIT: done_status = ST_COMMIT;
			OP_REVOKE: done_status = ST_REVOKE;
			default: begin
				done_status = pend_v_q ? ST_REPLAY : ST_NONE;
				used_next   = '0;
			end
		endcase
	end

	// Status toward the controller.
	always_comb begin
		stat.in_valid  = evt.valid;
		stat.in_op     = op_t'(evt.operation);
		stat.op        = op_q;
		stat.used_zero = (used_q == '0);
		stat.idx_last  = ({1'b0, idx_q} + CNT_W'(1)) == used_q;
		stat.tag_match = (r_fsb == fsb_q);
		stat.rev_match = (r_fsb == fsb_q) && (r_seq <= seq_q);
		stat.qualify   = (r_seq <= highest_q) && !revoked_q[idx_q];
		stat.pend_v    = pend_v_q;
		stat.out_free  = out_free;
	end

	// Captured event fields.
	always_ff @(posedge clk) begin
		if (load) begin
			op_q  <= op_t'(evt.operation);
			fsb_q <= evt.fs_block;
			pos_q <= evt.log_position;
			seq_q <= evt.sequence_req;
		end
	end

	// Scan bookkeeping, table state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_size_q <= 32'd1024;
			idx_q      <= '0;
			used_q     <= '0;
			highest_q  <= '0;
			revoked_q  <= '0;
			found_q    <= 1'b0;
			slot_q     <= '0;
			hit_q      <= 1'b0;
			pend_v_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				log_size_q <= cfg.data;
			end
			if (load) begin
				idx_q    <= '0;
				found_q  <= 1'b0;
				hit_q    <= 1'b0;
				pend_v_q <= 1'b0;
			end
			if (cmd.inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.tag_hit) begin
				found_q <= 1'b1;
				slot_q  <= idx_q;
			end
			if (cmd.rev_mark) begin
				revoked_q[idx_q] <= 1'b1;
				hit_q            <= 1'b1;
			end
			if (cmd.fin_keep) begin
				pend_v_q <= 1'b1;
			end
			if (tag_write) begin
				revoked_q[waddr] <= 1'b0;
			end
			if (cmd.done) begin
				used_q <= used_next;
				if (op_q == OP_COMMIT) begin
					highest_q <= high_next;
				end
				if (op_q == OP_FINISH) begin
					revoked_q <= '0;
				end
			end
		end
	end

	// Pending replay entry, held until the next one shows whether it is the last.
	always_ff @(posedge clk) begin
		if (cmd.fin_keep) begin
			pend_fsb_q <= r_fsb;
			pend_lb_q  <= r_lb;
			pend_seq_q <= r_seq;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.fin_keep && pend_v_q) || cmd.done) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (cmd.fin_keep && pend_v_q) begin
			out_status_q <= ST_REPLAY;
			out_fsb_q    <= pend_fsb_q;
			out_lb_q     <= pend_lb_q;
			out_seq_q    <= pend_seq_q;
			out_high_q   <= highest_q;
			out_cnt_q    <= '0;
			out_hit_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else if (cmd.done) begin
			out_status_q <= done_status;
			out_fsb_q    <= (done_status == ST_REPLAY) ? pend_fsb_q : '0;
			out_lb_q     <= (done_status == ST_REPLAY) ? pend_lb_q : '0;
			out_seq_q    <= (done_status == ST_REPLAY) ? pend_seq_q : '0;
			out_high_q   <= (op_q == OP_COMMIT) ? high_next : highest_q;
			out_cnt_q    <= used_next;
			out_hit_q    <= (op_q == OP_REVOKE) && hit_q;
			out_last_q   <= 1'b1;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.status         = out_status_q;
	assign res.out_fs_block   = out_fsb_q;
	assign res.out_log_block  = out_lb_q;
	assign res.entry_sequence = out_seq_q;
	assign res.last_committed = out_high_q;
	assign res.entry_count    = out_cnt_q;
	assign res.revoke_hit     = out_hit_q;
	assign res.last           = out_last_q;

endmodule

// ===== design/jrm_ctrl.sv =====
// Controller state machine that sequences table scans and result delivery.
module jrm_ctrl
	import jrm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  jrm_stat_t stat,
	output jrm_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_CHECK = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   stall;

	// A qualifying entry waits while the previous one cannot be handed out.
	assign stall = (stat.op == OP_FINISH) && stat.qualify && stat.pend_v && !stat.out_free;

	// Next state and commands.
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = 1'b1;
				if (stat.in_valid) begin
					state_next = ((stat.in_op == OP_COMMIT) || stat.used_zero) ? S_DONE : S_READ;
				end
			end
			S_READ: begin
				cmd.rd     = 1'b1;
				state_next = S_CHECK;
			end
			S_CHECK: begin
				if (!stall) begin
					case (stat.op)
						OP_TAG:    cmd.tag_hit  = stat.tag_match;
						OP_REVOKE: cmd.rev_mark = stat.rev_match;
						default:   cmd.fin_keep = (stat.op == OP_FINISH) && stat.qualify;
					endcase
					if (((stat.op == OP_TAG) && stat.tag_match) || stat.idx_last) begin
						state_next = S_DONE;
					end else begin
						cmd.inc    = 1'b1;
						state_next = S_READ;
					end
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.done   = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ===== design/journal_replay_map.sv =====
// Top level of the journal replay map: controller and datapath.
// The block builds the replay table for journal recovery from decoded log events
// and scans a 64-entry table held in one RAM entry by entry (read, then compare).
// A commit, or any event while the table is empty, skips the scan; a tag scan stops
// at the first match, a revoke or a finish scans all held entries, and a finish
// also waits while a result cannot be handed out. Every event ends only once the
// output register is free. A new event is accepted only when the previous one has
// finished, while its last result may still wait in the output register.
// Configuration writes are accepted at any time.
module journal_replay_map
	import jrm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	jrm_evt_if.sink   evt,
	jrm_res_if.source res,
	jrm_cfg_if.sink   cfg
);

	jrm_cmd_t  cmd;
	jrm_stat_t stat;

	jrm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	jrm_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.res    (res),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

// ===== tb/jrm_tb_pkg.sv =====
// Shared types of the journal replay map testbench.
`timescale 1ns / 100ps
package jrm_tb_pkg;
	import jrm_pkg::*;

	// One expected replay map result.
	typedef struct packed {
		status_t     status;
		logic [63:0] fs_block;
		logic [31:0] log_block;
		logic [31:0] seq;
		logic [31:0] committed;
		logic [6:0]  count;
		logic        hit;
		logic        last;
	} map_result_t;
endpackage

// ===== tb/tb.sv =====
// Testbench top for the journal replay map: predictor, stimulus tasks and result checker.
`timescale 1ns / 100ps
module tb;
	import jrm_pkg::*;
	import jrm_tb_pkg::*;

	logic clk;
	logic arst_n;

	jrm_evt_if evt ();
	jrm_res_if res ();
	jrm_cfg_if cfg ();

	journal_replay_map u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt.sink),
		.res    (res.source),
		.cfg    (cfg.sink)
	);

	// Predictor state of the replay table.
	logic [31:0] ring_size;
	logic [63:0] tbl_fsb [MAP_ENTRIES];
	logic [31:0] tbl_lb [MAP_ENTRIES];
	logic [31:0] tbl_seq [MAP_ENTRIES];
	logic        tbl_rev [MAP_ENTRIES];
	int          tbl_used;
	logic [31:0] top_commit;

	map_result_t pending_results[$];
	int          mismatches;
	int          results_seen;
	int          idle_cycles;
	logic        timed_out;
	int          burst_left;
	logic [63:0] recent_blocks[$];

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic map_result_t make_result(status_t st, logic [63:0] fsb, logic [31:0] lb,
			logic [31:0] sq, logic h, logic l);
		map_result_t r;
		r.status    = st;
		r.fs_block  = fsb;
		r.log_block = lb;
		r.seq       = sq;
		r.committed = top_commit;
		r.count     = tbl_used[6:0];
		r.hit       = h;
		r.last      = l;
		return r;
	endfunction

	// Updates the predicted table for one event and queues its results.
	task automatic predict_event(op_t op, logic [63:0] fsb, logic [31:0] pos, logic [31:0] sq);
		int slot;
		int n;
		int held;
		logic h;
		status_t st;
		logic [31:0] wrapped;
		slot = -1;
		h = 1'b0;
		n = 0;
		wrapped = (pos >= ring_size) ? pos - ring_size : pos;
		case (op)
			OP_TAG: begin
				st = ST_DROPPED;
				for (int i = 0; i < tbl_used; i++) begin
					if (slot < 0 && tbl_fsb[i] == fsb) begin
						slot = i;
						st = ST_UPDATED;
					end
				end
				if (slot < 0 && tbl_used < MAP_ENTRIES) begin
					slot = tbl_used;
					tbl_fsb[slot] = fsb;
					tbl_used++;
					st = ST_INSERTED;
				end
				if (slot >= 0) begin
					tbl_lb[slot] = wrapped;
					tbl_seq[slot] = sq;
					tbl_rev[slot] = 1'b0;
				end
				pending_results.push_back(make_result(st, 0, 0, 0, 1'b0, 1'b1));
			end
			OP_COMMIT: begin
				if (sq > top_commit) top_commit = sq;
				pending_results.push_back(make_result(ST_COMMIT, 0, 0, 0, 1'b0, 1'b1));
			end
			OP_REVOKE: begin
				for (int i = 0; i < tbl_used; i++) begin
					if (tbl_fsb[i] == fsb && tbl_seq[i] <= sq) begin
						tbl_rev[i] = 1'b1;
						h = 1'b1;
					end
				end
				pending_results.push_back(make_result(ST_REVOKE, 0, 0, 0, h, 1'b1));
			end
			default: begin
				held = tbl_used;
				tbl_used = 0;
				for (int i = 0; i < held; i++) begin
					if (tbl_seq[i] <= top_commit && !tbl_rev[i]) begin
						pending_results.push_back(make_result(ST_REPLAY, tbl_fsb[i], tbl_lb[i],
							tbl_seq[i], 1'b0, 1'b0));
						n++;
					end
				end
				for (int i = 0; i < MAP_ENTRIES; i++) tbl_rev[i] = 1'b0;
				if (n == 0)
					pending_results.push_back(make_result(ST_NONE, 0, 0, 0, 1'b0, 1'b1));
				else
					pending_results[$].last = 1'b1;
			end
		endcase
	endtask

	// Sends one event with bursty pacing and records its expected results.
	task automatic send_event(op_t op, logic [63:0] fsb, logic [31:0] pos, logic [31:0] sq);
		logic took;
		if (burst_left == 0) begin
			repeat ($urandom_range(6, 0)) @(posedge clk);
			burst_left = $urandom_range(12, 1);
		end
		burst_left--;
		evt.valid        <= 1'b1;
		evt.operation    <= op;
		evt.fs_block     <= fsb;
		evt.log_position <= pos;
		evt.sequence_req <= sq;
		// Ready only changes at a rising edge, so it is sampled in the middle of the cycle.
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = evt.ready;
			@(posedge clk);
		end
		predict_event(op, fsb, pos, sq);
		if (op == OP_TAG) recent_blocks.push_back(fsb);
		if (recent_blocks.size() > 16) void'(recent_blocks.pop_front());
		evt.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for all results, then for the block to finish any trailing work.
	task automatic drain_results();
		while (pending_results.size() != 0 && !timed_out) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Writes the log size register while the block is idle.
	task automatic write_log_size(logic [31:0] value);
		drain_results();
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		ring_size = value;
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand_block();
		return {$urandom(), $urandom()};
	endfunction

	// Directed: field extremes, every operation and each special case.
	task automatic test_directed();
		send_event(OP_FINISH, 0, 0, 0);
		send_event(OP_TAG, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(OP_TAG, 0, 1023, 0);
		send_event(OP_TAG, 64'h5, 1024, 3);
		send_event(OP_TAG, 64'h5, 2047, 4);
		send_event(OP_TAG, 64'h6, 2048, 5);
		send_event(OP_REVOKE, 64'h6, 0, 4);
		send_event(OP_REVOKE, 64'h6, 0, 5);
		send_event(OP_REVOKE, 64'h9, 0, 32'hFFFF_FFFF);
		send_event(OP_TAG, 64'h6, 7, 5);
		send_event(OP_COMMIT, 0, 0, 4);
		send_event(OP_COMMIT, 0, 0, 2);
		send_event(OP_FINISH, 0, 0, 0);
		send_event(OP_FINISH, 0, 0, 0);
		send_event(OP_COMMIT, 0, 0, 32'hFFFF_FFFF);
		send_event(OP_TAG, 64'hA5A5_5A5A_0F0F_F0F0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_event(OP_FINISH, 0, 0, 0);
	endtask

	// Fills the table past capacity so that new blocks are dropped.
	task automatic test_table_full();
		for (int i = 0; i < MAP_ENTRIES + 3; i++)
			send_event(OP_TAG, 64'h1000 + i, $urandom(), $urandom_range(100, 0));
		send_event(OP_TAG, 64'h1002, 5, 1);
		send_event(OP_FINISH, 0, 0, 0);
	endtask

	// Random transactions: tag/revoke/commit runs closed by a finish.
	task automatic test_random_transactions(int count);
		op_t op;
		logic [63:0] fsb;
		logic [31:0] base;
		for (int i = 0; i < count; i++) begin
			base = top_commit;
			case ($urandom_range(9, 0))
				0, 1, 2, 3: op = OP_TAG;
				4, 5: op = OP_REVOKE;
				6, 7: op = OP_COMMIT;
				8: op = OP_FINISH;
				default: op = op_t'($urandom_range(3, 0));
			endcase
			if (recent_blocks.size() != 0 && $urandom_range(2, 0) != 0)
				fsb = recent_blocks[$urandom_range(recent_blocks.size() - 1, 0)];
			else
				fsb = ($urandom_range(1, 0)) ? rand_block() : 64'($urandom_range(20, 0));
			send_event(op, fsb, ($urandom_range(3, 0) == 0) ? $urandom() :
				$urandom_range(2 * ring_size - 1, 0),
				($urandom_range(5, 0) == 0) ? $urandom() : base + $urandom_range(8, 0) - 2);
			if (i == count / 2) drain_results();
		end
		send_event(OP_FINISH, 0, 0, 0);
	endtask

	// Result stall pattern and checker.
	logic [7:0] stall_lfsr;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_lfsr <= 8'h5B;
			res.ready  <= 1'b0;
		end else begin
			stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^
				stall_lfsr[3]};
			res.ready  <= (stall_lfsr[7:6] != 2'b00) || stall_lfsr[2];
		end
	end

	always @(posedge clk) begin
		map_result_t want;
		map_result_t got;
		if (arst_n && res.valid && res.ready) begin
			results_seen++;
			got.status    = status_t'(res.status);
			got.fs_block  = res.out_fs_block;
			got.log_block = res.out_log_block;
			got.seq       = res.entry_sequence;
			got.committed = res.last_committed;
			got.count     = res.entry_count;
			got.hit       = res.revoke_hit;
			got.last      = res.last;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Watchdog over cycles without any transaction.
	always @(posedge clk) begin
		if ((evt.valid && evt.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			timed_out = 1'b1;
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		evt.valid    = 1'b0;
		evt.operation = OP_TAG;
		evt.fs_block = '0;
		evt.log_position = '0;
		evt.sequence_req = '0;
		cfg.valid    = 1'b0;
		cfg.data     = '0;
		ring_size    = 32'd1024;
		tbl_used     = 0;
		top_commit   = '0;
		mismatches   = 0;
		results_seen = 0;
		idle_cycles  = 0;
		timed_out    = 1'b0;
		burst_left   = 0;
		for (int i = 0; i < MAP_ENTRIES; i++) tbl_rev[i] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		write_log_size(32'd1);
		send_event(OP_TAG, 64'h77, 0, 1);
		send_event(OP_TAG, 64'h78, 1, 1);
		send_event(OP_FINISH, 0, 0, 0);
		write_log_size(32'hFFFF_FFFF);
		send_event(OP_TAG, 64'h79, 32'hFFFF_FFFF, 1);
		send_event(OP_TAG, 64'h7A, 32'hFFFF_FFFE, 1);
		send_event(OP_FINISH, 0, 0, 0);
		write_log_size(32'd64);
		test_table_full();
		test_random_transactions(8);
		write_log_size($urandom_range(5000, 2));
		test_random_transactions(8);
		drain_results();

		$display("Covered tags, commits, revokes, finishes, a full table and %0d results",
			results_seen);
		$display("under log sizes 1, 64, 1024, the 32-bit maximum and a random value.");
		if (mismatches == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ===== journal_replay_map.f =====
design/jrm_pkg.sv
design/jrm_if.sv
design/jrm_ram.sv
design/jrm_datapath.sv
design/jrm_ctrl.sv
design/journal_replay_map.sv
tb/jrm_tb_pkg.sv
tb/tb.sv
